### hdl/assert_macros.svh
// Assertion helpers shared by the date pipeline.
// Every check is sampled on the rising clock edge and is off while reset is high.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Plain property that must hold on every sampled edge.
`define ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// Implication checked in the same cycle.
`define ASSERT_IMPL(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

`endif

### hdl/sda_pkg.sv
`timescale 1ns / 1ps

package sda_pkg;

   localparam int SER_WIDTH   = 17;
   localparam int AMT_WIDTH   = 18;
   localparam int SPAN_WIDTH  = 9;
   localparam int DOY_WIDTH   = 9;
   localparam int TIDX_WIDTH  = 12;
   localparam int DAY_WIDTH   = 5;
   localparam int MONTH_WIDTH = 4;
   localparam int YEAR_WIDTH  = 12;
   localparam int SUM_WIDTH   = 22;
   localparam int TSUM_WIDTH  = 20;

   localparam int REQ_DATA_WIDTH = 40;
   localparam int RSP_DATA_WIDTH = 40;

   localparam logic [1:0] CMD_DAYS   = 2'd0;
   localparam logic [1:0] CMD_WEEKS  = 2'd1;
   localparam logic [1:0] CMD_MONTHS = 2'd2;
   localparam logic [1:0] CMD_YEARS  = 2'd3;

   localparam logic [SER_WIDTH-1:0]  SER_MIN        = 17'd367;
   localparam logic [SER_WIDTH-1:0]  SER_MAX        = 17'd109574;
   localparam logic [SER_WIDTH-1:0]  DAYS_PER_YEAR  = 17'd365;
   localparam logic [YEAR_WIDTH-1:0] YEAR_EPOCH     = 12'd1900;
   localparam int                    MONTHS_PER_YEAR = 12;

   // Year offsets from the epoch that are legal for a result (1901..2199).
   localparam int SPAN_MIN = 1;
   localparam int SPAN_MAX = 299;
   // Month index span*12 + month-1 for the same range.
   localparam int MONTH_INDEX_MIN = 12;
   localparam int MONTH_INDEX_MAX = 3599;

   // floor(s/365) = (s * RECIP_365) >> RECIP_365_SHIFT for all 17-bit s.
   localparam logic [17:0] RECIP_365       = 18'd183860;
   localparam int          RECIP_365_SHIFT = 26;
   // floor(t/12) = (t * RECIP_12) >> RECIP_12_SHIFT for all 12-bit t.
   localparam logic [13:0] RECIP_12        = 14'd5462;
   localparam int          RECIP_12_SHIFT  = 16;

   localparam int SPLIT_STAGES = 4;
   localparam int SHIFT_STAGES = 2;

   typedef struct packed {
      logic [1:0]                   cmd;
      logic signed [AMT_WIDTH-1:0]  amt;
      logic [SER_WIDTH-1:0]         ser;
      logic                         err;
      logic [SPAN_WIDTH-1:0]        span;
      logic [SER_WIDTH-1:0]         base;
      logic [DOY_WIDTH-1:0]         doy;
      logic [TIDX_WIDTH-1:0]        tidx;
      logic [DAY_WIDTH-1:0]         day;
      logic [MONTH_WIDTH-1:0]       month;
      logic                         leap;
   } item_type;

   typedef struct packed {
      logic [SER_WIDTH-1:0]   serial;
      logic [DAY_WIDTH-1:0]   day;
      logic [MONTH_WIDTH-1:0] month;
      logic [YEAR_WIDTH-1:0]  year;
      logic                   eom;
      logic                   err;
   } result_type;

   // Leap rule for year 1900+span: 1900 counts as leap, 2100 and 2200 do not.
   function automatic logic is_leap_span(input logic [SPAN_WIDTH-1:0] span);
      return (span[1:0] == 2'b00) && (span != 9'd200) && (span != 9'd300);
   endfunction

   // Serial of Dec 31 of the year before 1900+span.
   function automatic logic [SER_WIDTH-1:0] year_base(input logic [SPAN_WIDTH-1:0] span);
      logic [SER_WIDTH-1:0] days;
      logic [SER_WIDTH-1:0] leaps;
      days  = SER_WIDTH'(span) * DAYS_PER_YEAR;
      leaps = SER_WIDTH'(({1'b0, span} + 10'd3) >> 2);
      if (span > 9'd200) begin
         leaps = leaps - 17'd1;
      end
      return days + leaps;
   endfunction

   function automatic logic [DAY_WIDTH-1:0] month_len(input logic [MONTH_WIDTH-1:0] m,
                                                      input logic leap);
      logic [DAY_WIDTH-1:0] len;
      case (m)
         4'd2: begin
            len = leap ? 5'd29 : 5'd28;
         end
         4'd4, 4'd6, 4'd9, 4'd11: begin
            len = 5'd30;
         end
         default: begin
            len = 5'd31;
         end
      endcase
      return len;
   endfunction

   function automatic logic [DOY_WIDTH-1:0] month_start(input logic [MONTH_WIDTH-1:0] m,
                                                        input logic leap);
      logic [DOY_WIDTH-1:0] start;
      case (m)
         4'd2:    start = 9'd31;
         4'd3:    start = 9'd59;
         4'd4:    start = 9'd90;
         4'd5:    start = 9'd120;
         4'd6:    start = 9'd151;
         4'd7:    start = 9'd181;
         4'd8:    start = 9'd212;
         4'd9:    start = 9'd243;
         4'd10:   start = 9'd273;
         4'd11:   start = 9'd304;
         4'd12:   start = 9'd334;
         default: start = 9'd0;
      endcase
      if (leap && (m > 4'd2)) begin
         start = start + 9'd1;
      end
      return start;
   endfunction

endpackage

### hdl/serial_date_advance_unit.sv
`timescale 1ns / 1ps
// Channel  Dir  tdata (low bit up)                                   tuser
// req_     in   start_serial[16:0] amount[34:17] zero[39:35]         command[1:0]
// rsp_     out  result_serial[16:0] day_of_month[21:17]              range_error[0]
//               month_number[25:22] year_number[37:26]
//               end_of_month[38] zero[39]
//
// One word may enter every cycle while the result side keeps rsp_tready high; each word
// passes through the nine register stages in order: range/step, year quotient, year base,
// day of year, month, month/year step, month split, day clamp, output register.
// Reset is synchronous and clears only the stage valid bits.
// A stall on rsp_tready backs up stage by stage; empty stages keep taking words,
// so req_tready stays high until every stage holds a word.
module serial_date_advance_unit import sda_pkg::*; (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_tvalid,
   output logic                      req_tready,
   input  logic [REQ_DATA_WIDTH-1:0] req_tdata,   // start_serial, amount, zero pad
   input  logic [1:0]                req_tuser,   // command
   output logic                      rsp_tvalid,
   input  logic                      rsp_tready,
   output logic [RSP_DATA_WIDTH-1:0] rsp_tdata,   // result_serial, day_of_month,
                                                  // month_number, year_number,
                                                  // end_of_month, zero pad
   output logic [0:0]                rsp_tuser    // range_error
);

   logic [SER_WIDTH-1:0]        req_start;
   logic signed [AMT_WIDTH-1:0] req_amount;
   logic [1:0]                  req_command;
   logic signed [SUM_WIDTH-1:0] step_days;
   logic signed [SUM_WIDTH-1:0] target_sum;
   logic                        start_bad;
   logic                        target_bad;

   logic     entry_valid_ff;
   item_type entry_ff;
   item_type entry_in;
   logic     entry_ready;

   logic     split_in_ready;
   logic     split_valid;
   item_type split_item;
   logic     shift_in_ready;
   logic     shift_valid;
   item_type shift_item;
   logic     compose_in_ready;
   result_type result;

   // Unpack the request word.
   assign req_start   = req_tdata[SER_WIDTH-1:0];
   assign req_amount  = $signed(req_tdata[SER_WIDTH +: AMT_WIDTH]);
   assign req_command = req_tuser;

   // Entry stage: check the start, and for day or week steps move the serial here
   // so the split stage decodes the target date instead of the start date.
   always_comb begin
      if (req_command == CMD_WEEKS) begin
         step_days = (SUM_WIDTH'(req_amount) <<< 3) - SUM_WIDTH'(req_amount);
      end else begin
         step_days = SUM_WIDTH'(req_amount);
      end
      target_sum = $signed({5'b0, req_start}) + step_days;
      start_bad  = (req_start < SER_MIN) || (req_start > SER_MAX);
      target_bad = (target_sum < $signed({5'b0, SER_MIN}))
                || (target_sum > $signed({5'b0, SER_MAX}));

      entry_in     = '0;
      entry_in.cmd = req_command;
      entry_in.amt = req_amount;
      if (req_command == CMD_DAYS || req_command == CMD_WEEKS) begin
         entry_in.ser = target_sum[SER_WIDTH-1:0];
         entry_in.err = start_bad || target_bad;
      end else begin
         entry_in.ser = req_start;
         entry_in.err = start_bad;
      end
   end

   // Hold the entry word while the split stage is full.
   assign entry_ready = !entry_valid_ff || split_in_ready;
   assign req_tready  = entry_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         entry_valid_ff <= 1'b0;
      end else if (entry_ready) begin
         entry_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (entry_ready) begin
         entry_ff <= entry_in;
      end
   end

   sda_split u_split (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (entry_valid_ff),
      .in_ready  (split_in_ready),
      .in_item   (entry_ff),
      .out_valid (split_valid),
      .out_ready (shift_in_ready),
      .out_item  (split_item)
   );

   sda_shift u_shift (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (split_valid),
      .in_ready  (shift_in_ready),
      .in_item   (split_item),
      .out_valid (shift_valid),
      .out_ready (compose_in_ready),
      .out_item  (shift_item)
   );

   sda_compose u_compose (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (shift_valid),
      .in_ready   (compose_in_ready),
      .in_item    (shift_item),
      .out_valid  (rsp_tvalid),
      .out_ready  (rsp_tready),
      .out_result (result)
   );

   // Pack the response word; fields already read zero on a range error.
   assign rsp_tdata = {1'b0, result.eom, result.year, result.month, result.day, result.serial};
   assign rsp_tuser = result.err;

endmodule

### hdl/sda_split.sv
`timescale 1ns / 1ps

// Serial to year / day-of-year / month / day, four stages.
module sda_split import sda_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     in_valid,
   output logic     in_ready,
   input  item_type in_item,
   output logic     out_valid,
   input  logic     out_ready,
   output item_type out_item
);

   logic [SPLIT_STAGES-1:0] valid_ff;
   logic [SPLIT_STAGES-1:0] valid_in;
   logic [SPLIT_STAGES-1:0] stage_ready;
   item_type                item_ff [SPLIT_STAGES];
   item_type                item_in [SPLIT_STAGES];

   logic [34:0]            quo_prod;
   logic [MONTH_WIDTH-1:0] month_sel;

   always_comb begin
      stage_ready[SPLIT_STAGES-1] = !valid_ff[SPLIT_STAGES-1] || out_ready;
      for (int k = SPLIT_STAGES - 2; k >= 0; k--) begin
         stage_ready[k] = !valid_ff[k] || stage_ready[k+1];
      end
   end

   assign valid_in  = {valid_ff[SPLIT_STAGES-2:0], in_valid};
   assign in_ready  = stage_ready[0];
   assign out_valid = valid_ff[SPLIT_STAGES-1];
   assign out_item  = item_ff[SPLIT_STAGES-1];

   always_comb begin
      // year offset estimate: serial / 365
      item_in[0]      = in_item;
      quo_prod        = 35'(in_item.ser) * 35'(RECIP_365);
      item_in[0].span = quo_prod[RECIP_365_SHIFT +: SPAN_WIDTH];

      item_in[1]      = item_ff[0];
      item_in[1].base = year_base(item_ff[0].span);

      // estimate is one high when the serial lands on or before Dec 31 of the prior year
      item_in[2] = item_ff[1];
      if (item_ff[1].ser <= item_ff[1].base) begin
         item_in[2].span = item_ff[1].span - 9'd1;
         item_in[2].doy  = DOY_WIDTH'(item_ff[1].ser - item_ff[1].base + DAYS_PER_YEAR
                                     + SER_WIDTH'(is_leap_span(item_in[2].span)));
      end else begin
         item_in[2].doy  = DOY_WIDTH'(item_ff[1].ser - item_ff[1].base);
      end
      item_in[2].leap = is_leap_span(item_in[2].span);

      item_in[3] = item_ff[2];
      month_sel  = 4'd1;
      for (int k = 2; k <= MONTHS_PER_YEAR; k++) begin
         if (item_ff[2].doy > month_start(MONTH_WIDTH'(k), item_ff[2].leap)) begin
            month_sel = MONTH_WIDTH'(k);
         end
      end
      item_in[3].month = month_sel;
      item_in[3].day   = DAY_WIDTH'(item_ff[2].doy - month_start(month_sel, item_ff[2].leap));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         for (int k = 0; k < SPLIT_STAGES; k++) begin
            if (stage_ready[k]) begin
               valid_ff[k] <= valid_in[k];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k < SPLIT_STAGES; k++) begin
         if (stage_ready[k]) begin
            item_ff[k] <= item_in[k];
         end
      end
   end

endmodule

### hdl/sda_shift.sv
`timescale 1ns / 1ps

// Month and year stepping with range check, two stages.
module sda_shift import sda_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     in_valid,
   output logic     in_ready,
   input  item_type in_item,
   output logic     out_valid,
   input  logic     out_ready,
   output item_type out_item
);

   logic [SHIFT_STAGES-1:0] valid_ff;
   logic [SHIFT_STAGES-1:0] valid_in;
   logic [SHIFT_STAGES-1:0] stage_ready;
   item_type                item_ff [SHIFT_STAGES];
   item_type                item_in [SHIFT_STAGES];

   logic [12:0]                  month_base;
   logic signed [TSUM_WIDTH-1:0] month_index;
   logic signed [TSUM_WIDTH-1:0] year_index;
   logic [25:0]                  div_prod;
   logic [SPAN_WIDTH-1:0]        div_quo;

   always_comb begin
      stage_ready[SHIFT_STAGES-1] = !valid_ff[SHIFT_STAGES-1] || out_ready;
      for (int k = SHIFT_STAGES - 2; k >= 0; k--) begin
         stage_ready[k] = !valid_ff[k] || stage_ready[k+1];
      end
   end

   assign valid_in  = {valid_ff[SHIFT_STAGES-2:0], in_valid};
   assign in_ready  = stage_ready[0];
   assign out_valid = valid_ff[SHIFT_STAGES-1];
   assign out_item  = item_ff[SHIFT_STAGES-1];

   always_comb begin
      item_in[0]  = in_item;
      month_base  = 13'(in_item.span) * 13'd12 + 13'(in_item.month) - 13'd1;
      month_index = $signed({7'b0, month_base}) + TSUM_WIDTH'(in_item.amt);
      year_index  = $signed({11'b0, in_item.span}) + TSUM_WIDTH'(in_item.amt);
      unique case (in_item.cmd)
         CMD_DAYS, CMD_WEEKS: begin
            item_in[0].tidx = '0;
         end
         CMD_MONTHS: begin
            item_in[0].tidx = month_index[TIDX_WIDTH-1:0];
            if (month_index < MONTH_INDEX_MIN || month_index > MONTH_INDEX_MAX) begin
               item_in[0].err = 1'b1;
            end
         end
         CMD_YEARS: begin
            item_in[0].tidx = year_index[TIDX_WIDTH-1:0];
            if (year_index < SPAN_MIN || year_index > SPAN_MAX) begin
               item_in[0].err = 1'b1;
            end
         end
      endcase

      // split the month index back into year offset and month; a year step takes its index as the offset
      item_in[1] = item_ff[0];
      div_prod   = 26'(item_ff[0].tidx) * 26'(RECIP_12);
      div_quo    = div_prod[RECIP_12_SHIFT +: SPAN_WIDTH];
      unique case (item_ff[0].cmd)
         CMD_DAYS, CMD_WEEKS: begin
            item_in[1].span = item_ff[0].span;
         end
         CMD_MONTHS: begin
            item_in[1].span  = div_quo;
            item_in[1].month = MONTH_WIDTH'(item_ff[0].tidx - TIDX_WIDTH'(div_quo) * 12'd12
                                            + 12'd1);
         end
         CMD_YEARS: begin
            item_in[1].span = item_ff[0].tidx[SPAN_WIDTH-1:0];
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         for (int k = 0; k < SHIFT_STAGES; k++) begin
            if (stage_ready[k]) begin
               valid_ff[k] <= valid_in[k];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k < SHIFT_STAGES; k++) begin
         if (stage_ready[k]) begin
            item_ff[k] <= item_in[k];
         end
      end
   end

endmodule

### hdl/sda_compose.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"

// Day clamp, serial rebuild and the output register.
module sda_compose import sda_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       in_valid,
   output logic       in_ready,
   input  item_type   in_item,
   output logic       out_valid,
   input  logic       out_ready,
   output result_type out_result
);

   logic       clamp_valid_ff;
   item_type   clamp_ff;
   item_type   clamp_in;
   logic       clamp_ready;
   logic       out_valid_ff;
   result_type out_ff;
   result_type out_in;
   logic       out_stage_ready;
   logic [DAY_WIDTH-1:0] clamp_len;

   logic                 err_word;
   logic                 good_word;
   logic                 clamp_held;
   logic                 out_fields_zero;
   logic                 out_date_legal;
   logic                 out_serial_legal;
   logic [DAY_WIDTH-1:0] out_month_len;

   assign out_stage_ready = !out_valid_ff || out_ready;
   assign clamp_ready     = !clamp_valid_ff || out_stage_ready;
   assign in_ready        = clamp_ready;
   assign out_valid       = out_valid_ff;
   assign out_result      = out_ff;

   always_comb begin
      clamp_in      = in_item;
      clamp_in.leap = is_leap_span(in_item.span);
      clamp_len     = month_len(in_item.month, clamp_in.leap);
      unique case (in_item.cmd)
         CMD_DAYS, CMD_WEEKS: begin
            clamp_in.base = '0;
         end
         CMD_MONTHS: begin
            // short target month: pull the day back to its last day
            if (in_item.day > clamp_len) begin
               clamp_in.day = clamp_len;
            end
            clamp_in.base = year_base(in_item.span);
         end
         CMD_YEARS: begin
            // leap day into a common year becomes Feb 28
            if (in_item.day == 5'd29 && in_item.month == 4'd2 && !clamp_in.leap) begin
               clamp_in.day = 5'd28;
            end
            clamp_in.base = year_base(in_item.span);
         end
      endcase
   end

   always_comb begin
      out_in.day   = clamp_ff.day;
      out_in.month = clamp_ff.month;
      out_in.year  = YEAR_EPOCH + YEAR_WIDTH'(clamp_ff.span);
      out_in.eom   = clamp_ff.day == month_len(clamp_ff.month, clamp_ff.leap);
      out_in.err   = 1'b0;
      if (clamp_ff.cmd == CMD_DAYS || clamp_ff.cmd == CMD_WEEKS) begin
         out_in.serial = clamp_ff.ser;
      end else begin
         out_in.serial = clamp_ff.base
                       + SER_WIDTH'(month_start(clamp_ff.month, clamp_ff.leap))
                       + SER_WIDTH'(clamp_ff.day);
      end
      if (clamp_ff.err) begin
         out_in     = '0;
         out_in.err = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clamp_valid_ff <= 1'b0;
         out_valid_ff   <= 1'b0;
      end else begin
         if (clamp_ready) begin
            clamp_valid_ff <= in_valid;
         end
         if (out_stage_ready) begin
            out_valid_ff <= clamp_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (clamp_ready) begin
         clamp_ff <= clamp_in;
      end
      if (out_stage_ready) begin
         out_ff <= out_in;
      end
   end

   // Terms for the checks below; the year field maps back to its epoch offset.
   assign err_word         = out_valid_ff && out_ff.err;
   assign good_word        = out_valid_ff && !out_ff.err;
   assign clamp_held       = clamp_valid_ff && !out_stage_ready;
   assign out_fields_zero  = (out_ff.serial == '0) && (out_ff.day == '0)
                          && (out_ff.month == '0) && (out_ff.year == '0) && !out_ff.eom;
   assign out_month_len    = month_len(out_ff.month,
                                       is_leap_span(SPAN_WIDTH'(out_ff.year - YEAR_EPOCH)));
   assign out_date_legal   = (out_ff.month >= 4'd1) && (out_ff.month <= 4'd12)
                          && (out_ff.day >= 5'd1) && (out_ff.day <= out_month_len);
   assign out_serial_legal = (out_ff.serial >= SER_MIN) && (out_ff.serial <= SER_MAX);

   `ASSERT_IMPL(a_err_clears_fields, err_word, out_fields_zero, "error word carries nonzero fields")
   `ASSERT_IMPL(a_month_day_legal, good_word, out_date_legal, "calendar fields out of range")
   `ASSERT_IMPL(a_serial_legal, good_word, out_serial_legal, "good result serial outside window")
   `ASSERT_IMPL(a_stage_flow, clamp_held, !clamp_ready, "clamp stage advanced into a stall")

endmodule

### tb/tb_serial_date_advance_unit.sv
`timescale 1ns / 1ps

module tb_serial_date_advance_unit;
   import sda_pkg::*;

   localparam int FIRST_SERIAL = 367;
   localparam int LAST_SERIAL  = 109574;
   localparam int FIRST_YEAR   = 1901;
   localparam int LAST_YEAR    = 2199;
   localparam int RANDOM_WORDS = 1425;
   localparam int QUIET_LIMIT  = 5000;   // cycles with no handshake on either side
   localparam int TAIL_CYCLES  = 30;     // pipeline is nine stages deep

   typedef struct packed {
      logic [1:0]                  cmd;
      logic [SER_WIDTH-1:0]        start;
      logic signed [AMT_WIDTH-1:0] amount;
   } date_request_type;

   logic                      clock;
   logic                      reset;
   logic                      req_tvalid = 1'b0;
   logic                      req_tready;
   logic [REQ_DATA_WIDTH-1:0] req_tdata  = '0;   // start_serial, amount, zero pad
   logic [1:0]                req_tuser  = '0;   // command
   logic                      rsp_tvalid;
   logic                      rsp_tready = 1'b0;
   logic [RSP_DATA_WIDTH-1:0] rsp_tdata;         // result_serial, day_of_month,
                                                 // month_number, year_number,
                                                 // end_of_month, zero pad
   logic [0:0]                rsp_tuser;         // range_error

   date_request_type date_requests[$];
   result_type       predicted_dates[$];
   int               total_words  = 0;
   int               launched     = 0;
   int               mismatches   = 0;
   int               quiet_cycles = 0;

   serial_date_advance_unit DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // ---------------------------------------------------------------------
   // Calendar arithmetic: serial 1 is 1900-01-01, 1900 is a leap year
   // ---------------------------------------------------------------------
   function automatic bit leap_year(input int y);
      return (y % 4 == 0) && (y != 2100) && (y != 2200);
   endfunction

   // serial number of Dec 31 of the year before y
   function automatic int dec31_before(input int y);
      int yrs;
      int leap_days;
      yrs       = y - 1900;
      leap_days = (yrs + 3) / 4;
      if (y > 2100) begin
         leap_days = leap_days - 1;
      end
      return 365 * yrs + leap_days;
   endfunction

   function automatic int month_days(input int y, input int m);
      int len;
      case (m)
         2: begin
            len = leap_year(y) ? 29 : 28;
         end
         4, 6, 9, 11: begin
            len = 30;
         end
         default: begin
            len = 31;
         end
      endcase
      return len;
   endfunction

   function automatic int days_before_month(input int y, input int m);
      int acc;
      acc = 0;
      for (int k = 1; k < m; k++) begin
         acc = acc + month_days(y, k);
      end
      return acc;
   endfunction

   function automatic int serial_of(input int y, input int m, input int d);
      return dec31_before(y) + days_before_month(y, m) + d;
   endfunction

   // break a legal serial into calendar fields
   function automatic void split_date(input int s, output int d, output int m, output int y);
      int doy;
      y = s / 365 + 1900;
      if (s <= dec31_before(y)) begin
         y = y - 1;
      end
      doy = s - dec31_before(y);
      m = 1;
      while (m < 12 && doy > days_before_month(y, m + 1)) begin
         m = m + 1;
      end
      d = doy - days_before_month(y, m);
   endfunction

   // expected response word for one request
   function automatic result_type advance_date(input logic [1:0] cmd,
                                               input logic [SER_WIDTH-1:0] start,
                                               input logic [AMT_WIDTH-1:0] amt);
      result_type r;
      int s, n, t, d, m, y;
      r     = '0;
      r.err = 1'b1;
      s     = int'(start);
      n     = int'($signed(amt));
      if (s < FIRST_SERIAL || s > LAST_SERIAL) begin
         return r;
      end
      split_date(s, d, m, y);
      case (cmd)
         CMD_DAYS, CMD_WEEKS: begin
            s = s + ((cmd == CMD_DAYS) ? n : 7 * n);
            if (s < FIRST_SERIAL || s > LAST_SERIAL) begin
               return r;
            end
            split_date(s, d, m, y);
         end
         CMD_MONTHS: begin
            t = y * 12 + (m - 1) + n;
            if (t < FIRST_YEAR * 12 || t > LAST_YEAR * 12 + 11) begin
               return r;
            end
            y = t / 12;
            m = t % 12 + 1;
            // clamp to the length of the target month
            if (d > month_days(y, m)) begin
               d = month_days(y, m);
            end
            s = serial_of(y, m, d);
         end
         default: begin
            t = y + n;
            if (t < FIRST_YEAR || t > LAST_YEAR) begin
               return r;
            end
            y = t;
            // Feb 29 lands on Feb 28 in a common year
            if (m == 2 && d == 29 && !leap_year(y)) begin
               d = 28;
            end
            s = serial_of(y, m, d);
         end
      endcase
      r.serial = SER_WIDTH'(s);
      r.day    = DAY_WIDTH'(d);
      r.month  = MONTH_WIDTH'(m);
      r.year   = YEAR_WIDTH'(y);
      r.eom    = (d == month_days(y, m));
      r.err    = 1'b0;
      return r;
   endfunction

   // Idle percentages: sender 29 / receiver 58, then swapped, then none.
   function automatic int idle_pct(input bit sender);
      int pct;
      if (launched < total_words / 3) begin
         pct = sender ? 29 : 58;
      end else if (launched < (2 * total_words) / 3) begin
         pct = sender ? 58 : 29;
      end else begin
         pct = 0;
      end
      return pct;
   endfunction

   task automatic queue_date(input logic [1:0] cmd, input int start, input int amt);
      date_request_type w;
      w.cmd    = cmd;
      w.start  = SER_WIDTH'(start);
      w.amount = AMT_WIDTH'(amt);
      date_requests.push_back(w);
   endtask

   // ---------------------------------------------------------------------
   // Driver: present the next word once the previous one was taken
   // ---------------------------------------------------------------------
   always @(posedge clock) begin : drive_words
      date_request_type w;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || req_tready) begin
         if (date_requests.size() != 0 && $urandom_range(99) >= idle_pct(1'b1)) begin
            w = date_requests.pop_front();
            // the word is committed once shown, so predict it now to keep order
            predicted_dates.push_back(advance_date(w.cmd, w.start, w.amount));
            req_tdata  <= {5'd0, w.amount, w.start};
            req_tuser  <= w.cmd;
            req_tvalid <= 1'b1;
            launched   <= launched + 1;
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // ---------------------------------------------------------------------
   // Monitor: compare each taken word with the oldest prediction
   // ---------------------------------------------------------------------
   always @(posedge clock) begin : check_words
      result_type got;
      result_type want;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got.serial = rsp_tdata[16:0];
            got.day    = rsp_tdata[21:17];
            got.month  = rsp_tdata[25:22];
            got.year   = rsp_tdata[37:26];
            got.eom    = rsp_tdata[38];
            got.err    = rsp_tuser[0];
            if (predicted_dates.size() == 0) begin
               mismatches = mismatches + 1;
               if (mismatches <= 10) begin
                  $write("unexpected word: serial %0d day %0d month %0d",
                         got.serial, got.day, got.month);
                  $display(" year %0d eom %0b err %0b", got.year, got.eom, got.err);
               end
            end else begin
               want = predicted_dates.pop_front();
               if (got.serial != want.serial || got.day != want.day ||
                   got.month != want.month || got.year != want.year ||
                   got.eom != want.eom || got.err != want.err) begin
                  mismatches = mismatches + 1;
                  if (mismatches <= 10) begin
                     $write("mismatch at %0t: expected serial %0d day %0d month %0d",
                            $realtime, want.serial, want.day, want.month);
                     $display(" year %0d eom %0b err %0b", want.year, want.eom, want.err);
                     $write("   actual serial %0d day %0d month %0d",
                            got.serial, got.day, got.month);
                     $display(" year %0d eom %0b err %0b", got.year, got.eom, got.err);
                  end
               end
            end
         end
         rsp_tready <= ($urandom_range(99) >= idle_pct(1'b0));
      end
   end

   // Watchdog: give up when neither side moves a word for too long.
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles == QUIET_LIMIT) begin
            $display("tb_serial_date_advance_unit: FAIL");
            $finish;
         end
      end
   end

   // ---------------------------------------------------------------------
   // Stimulus and end of run
   // ---------------------------------------------------------------------
   initial begin : stimulus
      int pick, start, mag, amt, y, m;
      logic [1:0] cmd;
      reset = 1'b1;

      // range limits of the start serial and of day and week results
      queue_date(CMD_DAYS, FIRST_SERIAL, 0);
      queue_date(CMD_DAYS, LAST_SERIAL, 0);
      queue_date(CMD_DAYS, FIRST_SERIAL, -1);
      queue_date(CMD_DAYS, LAST_SERIAL, 1);
      queue_date(CMD_DAYS, FIRST_SERIAL, LAST_SERIAL - FIRST_SERIAL);
      queue_date(CMD_DAYS, FIRST_SERIAL - 1, 0);
      queue_date(CMD_DAYS, LAST_SERIAL + 1, 5);
      queue_date(CMD_YEARS, 0, 1);
      queue_date(CMD_WEEKS, 131071, -131072);
      queue_date(CMD_WEEKS, FIRST_SERIAL, 1);
      queue_date(CMD_WEEKS, LAST_SERIAL, -1);
      queue_date(CMD_WEEKS, 60000, 131071);
      queue_date(CMD_WEEKS, 60000, -131072);
      // short target month
      queue_date(CMD_MONTHS, serial_of(2001, 1, 31), 1);
      queue_date(CMD_MONTHS, serial_of(2004, 1, 31), 1);
      queue_date(CMD_MONTHS, serial_of(2100, 3, 31), -1);
      queue_date(CMD_MONTHS, serial_of(2001, 5, 31), 1);
      // month results at the edge of the year range
      queue_date(CMD_MONTHS, serial_of(1901, 1, 15), -1);
      queue_date(CMD_MONTHS, LAST_SERIAL, 1);
      queue_date(CMD_MONTHS, FIRST_SERIAL, 3599);
      queue_date(CMD_MONTHS, FIRST_SERIAL, -131072);
      // leap day and range limits under year steps
      queue_date(CMD_YEARS, serial_of(2000, 2, 29), 1);
      queue_date(CMD_YEARS, serial_of(2096, 2, 29), 4);
      queue_date(CMD_YEARS, serial_of(2000, 2, 29), 4);
      queue_date(CMD_YEARS, FIRST_SERIAL, -1);
      queue_date(CMD_YEARS, LAST_SERIAL, 1);
      queue_date(CMD_YEARS, FIRST_SERIAL, 298);
      queue_date(CMD_YEARS, FIRST_SERIAL, 131071);

      for (int i = 0; i < RANDOM_WORDS; i++) begin
         pick = $urandom_range(99);
         cmd  = 2'($urandom_range(3));
         if (pick < 6) begin
            // raw noise, often an illegal start
            queue_date(cmd, $urandom_range(131071), $urandom_range(262143));
         end else begin
            pick = $urandom_range(99);
            if (pick < 20) begin
               y     = $urandom_range(LAST_YEAR, FIRST_YEAR);
               m     = $urandom_range(12, 1);
               start = serial_of(y, m, month_days(y, m));
            end else if (pick < 30) begin
               y = 1904 + 4 * $urandom_range(73);
               if (y == 2100) begin
                  y = 2096;
               end
               start = serial_of(y, 2, 29);
            end else begin
               start = $urandom_range(LAST_SERIAL, FIRST_SERIAL);
            end
            pick = $urandom_range(99);
            if (pick < 10) begin
               amt = $urandom_range(262143);
            end else begin
               if (pick < 40) begin
                  mag = $urandom_range(40);
               end else begin
                  case (cmd)
                     CMD_DAYS:   mag = $urandom_range(LAST_SERIAL - FIRST_SERIAL);
                     CMD_WEEKS:  mag = $urandom_range(15601);
                     CMD_MONTHS: mag = $urandom_range(3600);
                     default:    mag = $urandom_range(300);
                  endcase
               end
               amt = $urandom_range(1) ? -mag : mag;
            end
            queue_date(cmd, start, amt);
         end
      end
      total_words = date_requests.size();

      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // drain: every word sent and every prediction compared
      while (date_requests.size() != 0 || req_tvalid || predicted_dates.size() != 0) begin
         @(posedge clock);
      end
      repeat (TAIL_CYCLES) @(posedge clock);

      if (mismatches == 0 && predicted_dates.size() == 0) begin
         $display("tb_serial_date_advance_unit: PASS");
      end else begin
         $display("tb_serial_date_advance_unit: FAIL");
      end
      $finish;
   end

endmodule
